/* src/ple_pkg.sv */
`default_nettype none

package ple_pkg;

  // fixed field widths of the command and result ports
  localparam int ACTION_W = 2;
  localparam int POS_W    = 9;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // defaults for the top level parameters
  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // datapath commands, one per cycle from the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CHECK,
    CMD_WALK,
    CMD_VAL_RD,
    CMD_VAL_CAP,
    CMD_VAL_WR,
    CMD_LNK_RD,
    CMD_GONE,
    CMD_UNLINK,
    CMD_PUSH,
    CMD_POP,
    CMD_ALLOC,
    CMD_SPLICE,
    CMD_SPL_PREV
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    action_t action;
    logic    err;
    logic    pos_one;
    logic    walk_done;
  } flags_t;

endpackage

`default_nettype wire

/* src/ple_ram.sv */
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/ple_ctrl.sv */
`default_nettype none

module ple_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  output logic                 out_strobe,
  input  wire ple_pkg::flags_t flags,
  output ple_pkg::cmd_t        cmd
);

  import ple_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_VRD,
    S_VCAP,
    S_VWR,
    S_LRD,
    S_GONE,
    S_UNLINK,
    S_PUSH,
    S_POP,
    S_ALLOC,
    S_SPL_RD,
    S_SPLICE,
    S_SPL_PREV
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, strobe_r;

  assign busy       = busy_r;
  assign out_strobe = strobe_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd = CMD_CHECK;
        if (flags.err) begin
          state_nxt = S_IDLE;
        end else if (flags.pos_one && flags.action == ACT_INSERT) begin
          state_nxt = S_POP;
        end else if (flags.pos_one && flags.action == ACT_REMOVE) begin
          state_nxt = S_GONE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd = CMD_WALK;
        if (flags.walk_done) begin
          unique case (flags.action)
            ACT_READ:   state_nxt = S_VRD;
            ACT_WRITE:  state_nxt = S_VWR;
            ACT_INSERT: state_nxt = S_POP;
            ACT_REMOVE: state_nxt = S_LRD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_VRD: begin
        cmd       = CMD_VAL_RD;
        state_nxt = S_VCAP;
      end
      S_VCAP: begin
        cmd       = CMD_VAL_CAP;
        state_nxt = S_IDLE;
      end
      S_VWR: begin
        cmd       = CMD_VAL_WR;
        state_nxt = S_IDLE;
      end
      S_LRD: begin
        cmd       = CMD_LNK_RD;
        state_nxt = S_GONE;
      end
      S_GONE: begin
        cmd       = CMD_GONE;
        state_nxt = S_UNLINK;
      end
      S_UNLINK: begin
        cmd       = CMD_UNLINK;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd       = CMD_PUSH;
        state_nxt = S_IDLE;
      end
      S_POP: begin
        cmd       = CMD_POP;
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        cmd       = CMD_ALLOC;
        state_nxt = flags.pos_one ? S_SPLICE : S_SPL_RD;
      end
      S_SPL_RD: begin
        cmd       = CMD_LNK_RD;
        state_nxt = S_SPLICE;
      end
      S_SPLICE: begin
        cmd       = CMD_SPLICE;
        state_nxt = flags.pos_one ? S_IDLE : S_SPL_PREV;
      end
      S_SPL_PREV: begin
        cmd       = CMD_SPL_PREV;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= (state_nxt != S_IDLE);
      strobe_r <= (state_nxt == S_IDLE) && (state_r != S_IDLE);
    end
  end

endmodule

`default_nettype wire

/* src/ple_dp.sv */
`default_nettype none

module ple_dp #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ple_pkg::cmd_t                   cmd,
  output ple_pkg::flags_t                      flags,
  input  wire logic [ple_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [ple_pkg::POS_W-1:0]       in_position,
  input  wire logic signed [DATA_WIDTH-1:0]    in_value,
  output logic signed [DATA_WIDTH-1:0]         out_read_value,
  output logic [ple_pkg::STATUS_W-1:0]         out_status,
  output logic [ple_pkg::COUNT_W-1:0]          out_count,
  output logic                                 out_empty_res
);

  import ple_pkg::*;

  localparam int SW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  // captured command
  action_t                 action_r;
  logic [POS_W-1:0]        pos_r;
  logic [DATA_WIDTH-1:0]   val_r;

  // list state
  logic [SW-1:0] first_r,     first_nxt;
  logic [SW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] count_r,     count_nxt;
  logic [CW-1:0] fill_r,      fill_nxt;

  // walk and splice working registers
  logic [SW-1:0]    cur_r,   cur_nxt;
  logic [SW-1:0]    gone_r,  gone_nxt;
  logic [SW-1:0]    fresh_r, fresh_nxt;
  logic [POS_W-1:0] rem_r,   rem_nxt;
  logic             lnk_fresh_r, lnk_fresh_nxt;

  // result
  status_t               status_r, status_nxt;
  logic [DATA_WIDTH-1:0] res_val_r, res_val_nxt;

  // memory ports
  logic                  lk_we, lk_re, vl_we, vl_re;
  logic [SW-1:0]         lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic [SW-1:0]         vl_waddr;
  logic [DATA_WIDTH-1:0] vl_rdata;

  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic            bad_pos, full, has_recyc;
  status_t         status_c;
  logic [SW-1:0]   cur_c, gone_c;

  assign pos_ext   = CMPW'(pos_r);
  assign cnt_ext   = CMPW'(count_r);
  assign full      = (count_r == CW'(CAPACITY));
  assign has_recyc = (fill_r != count_r);
  assign bad_pos   = (pos_r == '0) ||
                     ((action_r == ACT_INSERT) ? (pos_ext > cnt_ext + CMPW'(1))
                                               : (pos_ext > cnt_ext));

  always_comb begin
    if (bad_pos) begin
      status_c = ST_BAD_POS;
    end else if (action_r == ACT_INSERT && full) begin
      status_c = ST_FULL;
    end else begin
      status_c = ST_OK;
    end
  end

  // link just read, or the held slot when no step is in flight
  assign cur_c  = lnk_fresh_r ? lk_rdata : cur_r;
  assign gone_c = (pos_r == POS_W'(1)) ? first_r : lk_rdata;

  // action, err, pos_one, walk_done
  assign flags = {action_r, (status_c != ST_OK), (pos_r == POS_W'(1)), (rem_r == '0)};

  always_comb begin
    first_nxt     = first_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    gone_nxt      = gone_r;
    fresh_nxt     = fresh_r;
    rem_nxt       = rem_r;
    lnk_fresh_nxt = 1'b0;
    status_nxt    = status_r;
    res_val_nxt   = res_val_r;
    lk_we         = 1'b0;
    lk_waddr      = cur_r;
    lk_wdata      = fresh_r;
    lk_re         = 1'b0;
    lk_raddr      = cur_r;
    vl_we         = 1'b0;
    vl_waddr      = cur_r;
    vl_re         = 1'b0;
    unique case (cmd)
      CMD_NONE, CMD_LOAD: begin
      end
      CMD_CHECK: begin
        status_nxt  = status_c;
        res_val_nxt = (action_r == ACT_READ && status_c != ST_OK) ? '1 : '0;
        cur_nxt     = first_r;
        if (action_r == ACT_READ || action_r == ACT_WRITE) begin
          rem_nxt = pos_r - POS_W'(1);
        end else begin
          rem_nxt = pos_r - POS_W'(2);
        end
      end
      CMD_WALK: begin
        cur_nxt = cur_c;
        if (rem_r != '0) begin
          lk_re         = 1'b1;
          lk_raddr      = cur_c;
          rem_nxt       = rem_r - POS_W'(1);
          lnk_fresh_nxt = 1'b1;
        end
      end
      CMD_VAL_RD: begin
        vl_re = 1'b1;
      end
      CMD_VAL_CAP: begin
        res_val_nxt = vl_rdata;
      end
      CMD_VAL_WR: begin
        vl_we = 1'b1;
      end
      CMD_LNK_RD: begin
        lk_re = 1'b1;
      end
      CMD_GONE: begin
        gone_nxt = gone_c;
        lk_re    = 1'b1;
        lk_raddr = gone_c;
      end
      CMD_UNLINK: begin
        if (pos_r == POS_W'(1)) begin
          first_nxt = lk_rdata;
        end else begin
          lk_we    = 1'b1;
          lk_wdata = lk_rdata;
        end
      end
      CMD_PUSH: begin
        lk_we         = 1'b1;
        lk_waddr      = gone_r;
        lk_wdata      = free_head_r;
        free_head_nxt = gone_r;
        count_nxt     = count_r - CW'(1);
      end
      CMD_POP: begin
        lk_re    = has_recyc;
        lk_raddr = free_head_r;
      end
      CMD_ALLOC: begin
        if (has_recyc) begin
          fresh_nxt     = free_head_r;
          free_head_nxt = lk_rdata;
        end else begin
          fresh_nxt = fill_r[SW-1:0];
          fill_nxt  = fill_r + CW'(1);
        end
        vl_we    = 1'b1;
        vl_waddr = fresh_nxt;
      end
      CMD_SPLICE: begin
        lk_we    = 1'b1;
        lk_waddr = fresh_r;
        if (pos_r == POS_W'(1)) begin
          lk_wdata  = first_r;
          first_nxt = fresh_r;
        end else begin
          lk_wdata = lk_rdata;
        end
        count_nxt = count_r + CW'(1);
      end
      CMD_SPL_PREV: begin
        lk_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      free_head_r <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      lnk_fresh_r <= 1'b0;
    end else begin
      first_r     <= first_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      lnk_fresh_r <= lnk_fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      action_r <= action_t'(in_action);
      pos_r    <= in_position;
      val_r    <= in_value;
    end
    cur_r     <= cur_nxt;
    gone_r    <= gone_nxt;
    fresh_r   <= fresh_nxt;
    rem_r     <= rem_nxt;
    status_r  <= status_nxt;
    res_val_r <= res_val_nxt;
  end

  ple_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (lk_we),
    .wr_addr (lk_waddr),
    .wr_data (lk_wdata),
    .rd_en   (lk_re),
    .rd_addr (lk_raddr),
    .rd_data (lk_rdata)
  );

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (vl_we),
    .wr_addr (vl_waddr),
    .wr_data (val_r),
    .rd_en   (vl_re),
    .rd_addr (cur_r),
    .rd_data (vl_rdata)
  );

  assign out_read_value = res_val_r;
  assign out_status     = status_r;
  assign out_count      = COUNT_W'(count_r);
  assign out_empty_res  = (count_r == '0);

endmodule

`default_nettype wire

/* src/positional_list_engine_core.sv */
`default_nettype none

// Ordered list of up to CAPACITY signed values held as a linked chain of
// slots in two block RAMs (values and next-slot links), positions counted
// from 1. A command is transferred when start is high and busy is low; its
// result appears on the out_ ports for exactly one cycle, marked by
// out_strobe, and must be taken in that cycle since there is no back-pressure.
// Timing is set by the walk down the link RAM, one link per cycle through
// its single read port, so a command takes longer the further down the list
// its position lies; an invalid position or a full list is refused before
// any walk. busy drops in the strobe cycle, so the next command may be
// transferred while the result is shown. No clearing pass is needed after
// reset: unused slots are handed out in order from a fill count.
module positional_list_engine_core #(
  parameter int CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command transfer
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [ple_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [ple_pkg::POS_W-1:0]       in_position,
  input  wire logic signed [DATA_WIDTH-1:0]    in_value,
  // result, valid for the strobe cycle only
  output logic                                 out_strobe,
  output logic signed [DATA_WIDTH-1:0]         out_read_value,
  output logic [ple_pkg::STATUS_W-1:0]         out_status,
  output logic [ple_pkg::COUNT_W-1:0]          out_count,
  output logic                                 out_empty_res
);

  import ple_pkg::*;

  // command and status between sequencer and datapath
  cmd_t   cmd;
  flags_t flags;

  // sequencer: accepts a command, steps the walk and the relinking
  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .flags      (flags),
    .cmd        (cmd)
  );

  // datapath: list registers, link and value memories, result registers
  ple_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .flags          (flags),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_empty_res  (out_empty_res)
  );

endmodule

`default_nettype wire

/* src/ple_chk.sv */
`default_nettype none

module ple_chk #(
  parameter int CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_strobe,
  input wire logic signed [DATA_WIDTH-1:0] out_read_value,
  input wire logic [ple_pkg::STATUS_W-1:0] out_status,
  input wire logic [ple_pkg::COUNT_W-1:0]  out_count,
  input wire logic                         out_empty_res
);

  import ple_pkg::*;

  // a transfer always raises busy in the cycle after it
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer did not raise busy");

  // no two result strobes come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back to back result strobes");

  // a rejected command leaves the count alone
  a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ST_OK |-> $stable(out_count))
    else $error("count changed on a rejected command");

  // full is only reported with the list at capacity, and never as empty
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_FULL |-> out_count == COUNT_W'(CAPACITY) && !out_empty_res)
    else $error("full reported below capacity");

  // an insert refused on a full list reads as zero
  a_bad_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_FULL |-> out_read_value == '0)
    else $error("read value not zero on full insert");

endmodule

bind positional_list_engine_core ple_chk #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_ple_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_count      (out_count),
  .out_empty_res  (out_empty_res)
);

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

// drives list commands into the engine, mirrors the list in a queue and
// checks every result strobe against the oldest outstanding prediction
module testbench;
  import ple_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP       = DEF_CAPACITY;
  localparam int DW        = DEF_DATA_WIDTH;
  localparam int MAX_POS   = (1 << POS_W) - 1;
  // worst walk runs the length of the list, leave plenty of slack
  localparam int DRAIN     = CAP + 20;
  localparam int LIMIT     = 1500000;
  localparam int PHASE_LEN = 75;
  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAP);

  // one result as the engine reports it
  typedef struct {
    logic signed [DW-1:0] rd;
    status_t              st;
    logic [COUNT_W-1:0]   cnt;
    logic                 emp;
  } list_res_t;

  // a directed command, with a hand-written result where it is obvious
  typedef struct {
    action_t              act;
    logic [POS_W-1:0]     pos;
    logic signed [DW-1:0] val;
    bit                   typed;
    list_res_t            res;
  } cmd_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [ACTION_W-1:0]  in_action;
  logic [POS_W-1:0]     in_position;
  logic signed [DW-1:0] in_value;
  logic                 out_strobe;
  logic signed [DW-1:0] out_read_value;
  logic [STATUS_W-1:0]  out_status;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_empty_res;

  // hand-written result travelling alongside the command on the ports
  bit        row_typed;
  list_res_t row_res;

  logic signed [DW-1:0] held_values[$];    // mirror of the list, position 1 first
  list_res_t            awaited_results[$];
  cmd_row_t             directed_rows[$];
  int                   mismatch_count = 0;
  int                   cycle_count    = 0;
  int                   idle_pct       = 0;

  always #5 clk = ~clk;

  positional_list_engine_core #(
    .CAPACITY   (CAP),
    .DATA_WIDTH (DW)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_empty_res  (out_empty_res)
  );

  // list semantics: bad positions change nothing, a full list refuses inserts
  function automatic list_res_t apply_action(action_t act, int p,
                                             logic signed [DW-1:0] val);
    list_res_t r;
    int        n;
    n     = held_values.size();
    r.rd  = '0;
    r.st  = ST_OK;
    if (act == ACT_INSERT) begin
      // position count+1 appends
      if (p < 1 || p > n + 1) begin
        r.st = ST_BAD_POS;
      end else if (n == CAP) begin
        r.st = ST_FULL;
      end else begin
        held_values.insert(p - 1, val);
      end
    end else if (p < 1 || p > n) begin
      r.st = ST_BAD_POS;
      // a bad read shows all ones, other actions show zero
      if (act == ACT_READ) r.rd = '1;
    end else begin
      case (act)
        ACT_READ:  r.rd = held_values[p - 1];
        ACT_WRITE: held_values[p - 1] = val;
        default:   held_values.delete(p - 1);
      endcase
    end
    r.cnt = COUNT_W'(held_values.size());
    r.emp = (held_values.size() == 0);
    return r;
  endfunction

  // result check first, then the prediction for a command taken at this edge,
  // so a result and the next transfer on the same edge stay in order
  always @(posedge clk) begin : check_and_predict
    list_res_t want;
    list_res_t got;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: rd %0d st %0d cnt %0d emp %0b",
                 $time, out_read_value, out_status, out_count, out_empty_res);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_read_value !== want.rd) begin
          $display("%0t: read_value expected %0d actual %0d", $time, want.rd,
                   out_read_value);
          mismatch_count++;
        end
        if (out_status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_status);
          mismatch_count++;
        end
        if (out_count !== want.cnt) begin
          $display("%0t: count expected %0d actual %0d", $time, want.cnt, out_count);
          mismatch_count++;
        end
        if (out_empty_res !== want.emp) begin
          $display("%0t: empty_res expected %0b actual %0b", $time, want.emp,
                   out_empty_res);
          mismatch_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      // the mirror always advances; a typed row overrides what it predicts
      got = apply_action(action_t'(in_action), int'(in_position), in_value);
      if (row_typed) got = row_res;
      awaited_results.push_back(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void add_row(action_t act, int p, logic [DW-1:0] val, bit typed,
                                  logic [DW-1:0] rd, status_t st, int cnt, bit emp);
    cmd_row_t row;
    row.act       = act;
    row.pos       = POS_W'(p);
    row.val       = val;
    row.typed     = typed;
    row.res.rd    = rd;
    row.res.st    = st;
    row.res.cnt   = COUNT_W'(cnt);
    row.res.emp   = emp;
    directed_rows.push_back(row);
  endfunction

  // called on a falling edge; returns on the falling edge after the transfer
  task automatic send_cmd(action_t act, int p, logic [DW-1:0] val, bit typed,
                          list_res_t res);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_action   <= act;
    in_position <= POS_W'(p);
    in_value    <= val;
    row_typed   <= typed;
    row_res     <= res;
    // busy as it stood just before the edge decides the transfer
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // extremes turn up often, the rest is uniform
  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(DW-1){1'b0}}};
      1:       return {1'b0, {(DW-1){1'b1}}};
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    list_res_t no_res;
    cmd_row_t  row;
    action_t   act;
    int        n;
    int        p;
    int        r;
    int        target;
    bit        grow;

    no_res      = '{rd: '0, st: ST_OK, cnt: '0, emp: 1'b0};
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = ACT_READ;
    in_position = '0;
    in_value    = '0;
    row_typed   = 1'b0;
    row_res     = no_res;

    // synchronous reset, released on a falling edge
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every access on the empty list is a bad position
    add_row(ACT_READ,   1,       '0, 1, '1, ST_BAD_POS, 0, 1);
    add_row(ACT_REMOVE, 1,       '0, 1, '0, ST_BAD_POS, 0, 1);
    add_row(ACT_WRITE,  MAX_POS, '1, 1, '0, ST_BAD_POS, 0, 1);
    add_row(ACT_INSERT, 0,       '1, 1, '0, ST_BAD_POS, 0, 1);
    add_row(ACT_INSERT, 2,       '1, 1, '0, ST_BAD_POS, 0, 1);
    // build the list at the front, at the back and in the middle
    add_row(ACT_INSERT, 1, 32'h8000_0000, 1, '0, ST_OK, 1, 0);
    add_row(ACT_INSERT, 2, 32'h7FFF_FFFF, 0, '0, ST_OK, 0, 0);
    add_row(ACT_INSERT, 1, 32'hFFFF_FFFF, 0, '0, ST_OK, 0, 0);
    add_row(ACT_INSERT, 3, 32'h0000_0005, 0, '0, ST_OK, 0, 0);
    for (int i = 1; i <= 4; i++) add_row(ACT_READ, i, '0, 0, '0, ST_OK, 0, 0);
    // just beyond the end, position zero and an insert two past the end
    add_row(ACT_READ,   5, '0, 1, '1, ST_BAD_POS, 4, 0);
    add_row(ACT_READ,   0, '0, 1, '1, ST_BAD_POS, 4, 0);
    add_row(ACT_INSERT, 6, '1, 1, '0, ST_BAD_POS, 4, 0);
    add_row(ACT_WRITE,  2, 32'h0000_0000, 0, '0, ST_OK, 0, 0);
    add_row(ACT_WRITE,  4, 32'h5555_AAAA, 0, '0, ST_OK, 0, 0);
    add_row(ACT_READ,   2, '0, 0, '0, ST_OK, 0, 0);
    add_row(ACT_READ,   4, '0, 0, '0, ST_OK, 0, 0);
    // take it apart from the back and the front, down to empty and past it
    add_row(ACT_REMOVE, 4, '0, 0, '0, ST_OK, 0, 0);
    add_row(ACT_REMOVE, 1, '0, 0, '0, ST_OK, 0, 0);
    add_row(ACT_REMOVE, 2, '0, 0, '0, ST_OK, 0, 0);
    add_row(ACT_REMOVE, 1, '0, 1, '0, ST_OK, 0, 1);
    add_row(ACT_REMOVE, 1, '0, 1, '0, ST_BAD_POS, 0, 1);

    idle_pct = 20;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_cmd(row.act, row.pos, row.val, row.typed, row.res);
    end

    // fill to capacity at random places, then the full list cases
    while (held_values.size() < CAP) begin
      send_cmd(ACT_INSERT, $urandom_range(1, held_values.size() + 1), pick_value(), 0,
               no_res);
    end
    send_cmd(ACT_INSERT, 100,     '1, 1, '{rd: '0, st: ST_FULL,    cnt: CAP_CNT, emp: 1'b0});
    send_cmd(ACT_INSERT, CAP + 1, '0, 1, '{rd: '0, st: ST_FULL,    cnt: CAP_CNT, emp: 1'b0});
    send_cmd(ACT_INSERT, CAP + 2, '0, 1, '{rd: '0, st: ST_BAD_POS, cnt: CAP_CNT, emp: 1'b0});
    send_cmd(ACT_READ,   CAP,     '0, 0, no_res);

    // random part: the list size drifts towards a moving target so that it
    // spends time near empty, at mid sizes and at capacity
    target = 0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 36 : (phase == 1) ? 77 : 0;
      for (int k = 0; k < PHASE_LEN; k++) begin
        n = held_values.size();
        if (n == target) begin
          target = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20)
                                              : $urandom_range(20, CAP);
        end
        grow = (n < target);
        r    = $urandom_range(0, 99);
        if (r < 20)                    act = ACT_READ;
        else if (r < 40)               act = ACT_WRITE;
        else if (r < (grow ? 85 : 55)) act = ACT_INSERT;
        else                           act = ACT_REMOVE;
        // mostly legal positions, some noise over the whole field
        if ($urandom_range(0, 9) == 0) begin
          p = $urandom_range(0, MAX_POS);
        end else if (act == ACT_INSERT) begin
          p = $urandom_range(1, n + 1);
        end else begin
          p = (n == 0) ? $urandom_range(0, 2) : $urandom_range(1, n);
        end
        send_cmd(act, p, pick_value(), 0, no_res);
      end
    end
    start <= 1'b0;

    // drain, then a quiet spell to catch stray strobes
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/ple_pkg.sv
src/ple_ram.sv
src/ple_ctrl.sv
src/ple_dp.sv
src/positional_list_engine_core.sv
src/ple_chk.sv
verif/testbench.sv
